>>> rtl/ile_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg
// Shared constants and types of the indexed list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

	// Store size and the derived widths
	localparam int DEPTH = 64;
	localparam int AW    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	// width that holds any nonnegative position and any count
	localparam int PW    = (CW > 7) ? CW : 7;
	localparam int DW    = 32;

	// Request codes
	localparam logic [2:0] REQ_GET    = 3'd0;
	localparam logic [2:0] REQ_HEAD   = 3'd1;
	localparam logic [2:0] REQ_TAIL   = 3'd2;
	localparam logic [2:0] REQ_BEFORE = 3'd3;
	localparam logic [2:0] REQ_DELETE = 3'd4;

	// Status codes
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	// One finished result
	typedef struct packed {
		logic signed [DW-1:0] read_value;
		logic [1:0]           status;
		logic [CW-1:0]        length;
	} res_t;

	// Memory access requested by the sequencer
	typedef struct packed {
		logic          rd_en;
		logic [AW-1:0] rd_addr;
		logic          wr_en;
		logic [AW-1:0] wr_addr;
		logic [DW-1:0] wr_data;
	} ram_req_t;

endpackage

>>> rtl/ile_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ile_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/ile_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_ctrl
// Request sequencer: checks positions, reads the store and shifts entries
// one per cycle through the memory for inserts and deletes.
// ----------------------------------------------------------------------------
module ile_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0]                 req_type,
	input  logic signed [7:0]          position,
	input  logic signed [ile_pkg::DW-1:0] item_value,
	input  logic                       out_free,
	output logic                       push,
	output ile_pkg::res_t              res,
	output ile_pkg::ram_req_t          ram,
	input  logic [ile_pkg::DW-1:0]     rd_data
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_GET   = 6'b000010,
		S_MOVE  = 6'b000100,
		S_DRAIN = 6'b001000,
		S_PUT   = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t                        state_q;
	logic [ile_pkg::CW-1:0]        count_q;
	logic [ile_pkg::AW-1:0]        ptr_q;
	logic [ile_pkg::AW-1:0]        lim_q;
	logic                          dir_up_q;
	logic [ile_pkg::DW-1:0]        val_q;
	ile_pkg::res_t                 res_q;
	logic                          pend_s1;
	logic [ile_pkg::AW-1:0]        addr_s1;

	logic                          accept;
	logic [ile_pkg::PW-1:0]        pos_u;
	logic [ile_pkg::PW-1:0]        cnt_p;
	logic [ile_pkg::PW-1:0]        cnt_m1;
	logic [ile_pkg::PW-1:0]        ins_pos;
	logic                          get_ok;
	logic                          ins_ok;
	logic                          full;
	logic [ile_pkg::CW-1:0]        cnt_inc;
	logic [ile_pkg::CW-1:0]        cnt_dec;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// Decode the position against the current length
	always_comb begin
		pos_u  = ile_pkg::PW'(position[6:0]);
		cnt_p  = ile_pkg::PW'(count_q);
		cnt_m1 = cnt_p - ile_pkg::PW'(1);
		case (req_type)
			ile_pkg::REQ_HEAD:   ins_pos = '0;
			ile_pkg::REQ_TAIL:   ins_pos = cnt_p;
			ile_pkg::REQ_BEFORE: ins_pos = position[7] ? '0 : pos_u;
			default:             ins_pos = '0;
		endcase
		get_ok  = !position[7] && (pos_u < cnt_p);
		ins_ok  = (ins_pos <= cnt_p);
		full    = (count_q == ile_pkg::CW'(ile_pkg::DEPTH));
		cnt_inc = count_q + ile_pkg::CW'(1);
		cnt_dec = count_q - ile_pkg::CW'(1);
	end

	// Drive the memory: a get read on accept, one read a cycle while shifting,
	// and the moved entry or the new value on the write port
	always_comb begin
		ram.rd_en   = 1'b0;
		ram.rd_addr = ptr_q;
		if (accept && req_type == ile_pkg::REQ_GET) begin
			ram.rd_en   = 1'b1;
			ram.rd_addr = pos_u[ile_pkg::AW-1:0];
		end else if (state_q == S_MOVE) begin
			ram.rd_en = 1'b1;
		end
		ram.wr_en   = pend_s1 || (state_q == S_PUT);
		ram.wr_addr = lim_q;
		ram.wr_data = val_q;
		if (pend_s1) begin
			ram.wr_addr = dir_up_q ? addr_s1 + ile_pkg::AW'(1) : addr_s1 - ile_pkg::AW'(1);
			ram.wr_data = rd_data;
		end
	end

	// Sequence each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			ptr_q    <= '0;
			lim_q    <= '0;
			dir_up_q <= 1'b0;
			val_q    <= '0;
			res_q    <= '0;
			pend_s1  <= 1'b0;
			addr_s1  <= '0;
		end else begin
			pend_s1 <= (state_q == S_MOVE);
			addr_s1 <= ptr_q;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						res_q.read_value <= '1;
						res_q.status     <= ile_pkg::ST_BADPOS;
						res_q.length     <= count_q;
						state_q          <= S_RESP;
						case (req_type)
							ile_pkg::REQ_GET: begin
								if (get_ok) begin
									state_q <= S_GET;
								end
							end
							ile_pkg::REQ_HEAD, ile_pkg::REQ_TAIL, ile_pkg::REQ_BEFORE: begin
								if (ins_ok && full) begin
									res_q.status <= ile_pkg::ST_FULL;
								end else if (ins_ok) begin
									val_q    <= item_value;
									lim_q    <= ins_pos[ile_pkg::AW-1:0];
									ptr_q    <= cnt_m1[ile_pkg::AW-1:0];
									dir_up_q <= 1'b1;
									state_q  <= (ins_pos == cnt_p) ? S_PUT : S_MOVE;
								end
							end
							ile_pkg::REQ_DELETE: begin
								if (get_ok && pos_u == cnt_m1) begin
									res_q.status <= ile_pkg::ST_DONE;
									res_q.length <= cnt_dec;
									count_q      <= cnt_dec;
								end else if (get_ok) begin
									ptr_q    <= pos_u[ile_pkg::AW-1:0] + ile_pkg::AW'(1);
									lim_q    <= cnt_m1[ile_pkg::AW-1:0];
									dir_up_q <= 1'b0;
									state_q  <= S_MOVE;
								end
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_GET: begin
					res_q.read_value <= rd_data;
					res_q.status     <= ile_pkg::ST_DONE;
					state_q          <= S_RESP;
				end
				S_MOVE: begin
					ptr_q <= dir_up_q ? ptr_q - ile_pkg::AW'(1) : ptr_q + ile_pkg::AW'(1);
					if (ptr_q == lim_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (dir_up_q) begin
						state_q <= S_PUT;
					end else begin
						res_q.status <= ile_pkg::ST_DONE;
						res_q.length <= cnt_dec;
						count_q      <= cnt_dec;
						state_q      <= S_RESP;
					end
				end
				S_PUT: begin
					res_q.status <= ile_pkg::ST_DONE;
					res_q.length <= cnt_inc;
					count_q      <= cnt_inc;
					state_q      <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign push = (state_q == S_RESP) && out_free;
	assign res  = res_q;

	// Length never exceeds the store size
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ile_pkg::CW'(ile_pkg::DEPTH))
		else $error("entry count above store size");

	// Length changes only on the way into the response state
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> state_q == S_RESP)
		else $error("entry count changed outside a response");

	// A move never writes the entry it reads in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 && ram.rd_en) |-> ram.wr_addr != ram.rd_addr)
		else $error("shift write collides with shift read");

	// After a handoff the sequencer is free again
	assert property (@(posedge clk) disable iff (!arst_n)
		push |=> state_q == S_IDLE)
		else $error("sequencer did not return to idle after handoff");

endmodule

>>> rtl/indexed_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of signed 32-bit values with get, insert and delete by position.
// ----------------------------------------------------------------------------
// The block takes one request at a time and returns one result per request.
// Entries live in a single RAM with one read and one write port, so an insert
// or delete moves one entry per cycle. An insert at the tail and a delete of
// the last entry move no entry; an insert at a position p below the length
// moves the entries from p up, and a delete at any other position p moves the
// entries above p. Results sit in an output register, so the next request is
// taken while a result waits. No clearing pass is needed after reset; the
// value of an entry beyond the current length never reaches a result.
module indexed_list_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    req_type,
	input  logic signed [7:0]             position,
	input  logic signed [ile_pkg::DW-1:0] item_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [ile_pkg::DW-1:0] read_value,
	output logic [1:0]                    status,
	output logic [ile_pkg::CW-1:0]        length
);

	ile_pkg::ram_req_t       ram;
	logic [ile_pkg::DW-1:0]  rd_data;
	ile_pkg::res_t           res;
	logic                    push;
	logic                    out_free;
	logic                    out_valid_q;
	ile_pkg::res_t           out_q;

	ile_ram #(
		.WIDTH(ile_pkg::DW),
		.DEPTH(ile_pkg::DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (ram.wr_en),
		.wr_addr(ram.wr_addr),
		.wr_data(ram.wr_data),
		.rd_en  (ram.rd_en),
		.rd_addr(ram.rd_addr),
		.rd_data(rd_data)
	);

	ile_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.position  (position),
		.item_value(item_value),
		.out_free  (out_free),
		.push      (push),
		.res       (res),
		.ram       (ram),
		.rd_data   (rd_data)
	);

	// Output register: load a finished result, drop it once taken
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_q.read_value;
	assign status     = out_q.status;
	assign length     = out_q.length;

endmodule
